// File: src/pure_pursuit_steering_macros.svh
// ----------------------------------------------------------------------------
// Pure pursuit steering assertion macros
// Concurrent assertion helpers for the steering block; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_STEERING_MACROS_SVH
`define PURE_PURSUIT_STEERING_MACROS_SVH

`ifndef SYNTH
`define PPS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pps: invariant violated");
`define PPS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pps: implication violated");
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pps: next-cycle check violated");
`else
`define PPS_ASSERT_ALWAYS(label, cond)
`define PPS_ASSERT_IMPLY(label, ante, cons)
`define PPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering package
// Shared constants, codes and state types of the steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int LEN_W      = $clog2(MAX_POINTS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_POINTS);

  // Shared divider: 81-bit dividend, 64-bit divisor, one quotient bit a cycle.
  localparam int DIV_N_W   = 81;
  localparam int DIV_D_W   = 64;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam logic [63:0] MIN_DIST_SQ = 64'd4294967;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

  localparam logic [30:0] RST_LOOKAHEAD = 31'd32768;
  localparam logic [30:0] RST_SPEED     = 31'd19661;
  localparam logic [30:0] RST_GAIN      = 31'd65536;

  typedef enum logic [1:0] {
    CFG_LOOKAHEAD = 2'd0,
    CFG_SPEED     = 2'd1,
    CFG_GAIN      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CMD     = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_STORED  = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CGO,
    S_CWAIT,
    S_SGO,
    S_SWAIT,
    S_MULT,
    S_YSUM,
    S_GAIN,
    S_AGO,
    S_AWAIT,
    S_RESP
  } state_t;

endpackage

// File: src/pps_path_mem.sv
// ----------------------------------------------------------------------------
// Path point memory
// One write port and one registered read port holding the x and y of each point.
// ----------------------------------------------------------------------------
module pps_path_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [pps_pkg::IDX_W-1:0]  waddr,
  input  logic [31:0]                wx,
  input  logic [31:0]                wy,
  input  logic                       re,
  input  logic [pps_pkg::IDX_W-1:0]  raddr,
  output logic [31:0]                rx,
  output logic [31:0]                ry
);

  logic [63:0] mem [pps_pkg::MAX_POINTS];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rx = rdata_r[63:32];
  assign ry = rdata_r[31:0];

endmodule

// File: src/pps_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pps_pkg::DIV_N_W-1:0]  dividend,
  input  logic [pps_pkg::DIV_D_W-1:0]  divisor,
  output logic                         done,
  output logic [pps_pkg::DIV_N_W-1:0]  quotient
);

  logic                            run_r;
  logic                            done_r;
  logic [pps_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [pps_pkg::DIV_N_W-1:0]     dvd_r;
  logic [pps_pkg::DIV_D_W-1:0]     rem_r;
  logic [pps_pkg::DIV_D_W-1:0]     den_r;
  logic [pps_pkg::DIV_D_W:0]       shifted;
  logic [pps_pkg::DIV_D_W:0]       diff;
  logic                            ge;

  // The remainder stays below the divisor, so one extra bit holds the shift.
  always_comb begin
    shifted = {rem_r, dvd_r[pps_pkg::DIV_N_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= pps_pkg::DIV_CNT_W'(pps_pkg::DIV_N_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (run_r) begin
      dvd_r <= {dvd_r[pps_pkg::DIV_N_W-2:0], ge};
      rem_r <= ge ? diff[pps_pkg::DIV_D_W-1:0] : shifted[pps_pkg::DIV_D_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// File: src/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering
// Path store and look-ahead steering command for a planar robot.
// ----------------------------------------------------------------------------
// A store word goes straight to its response. A query word walks the stored
// path through the point memory, one point issued per cycle, until it finds
// the carrot; then come three passes of the shared restoring divider (cosine,
// sine, then curvature after the multiply, sum and gain states). A zero
// quaternion skips two divider passes and a near-zero offset skips the
// third. Results wait in an output register; the next word is accepted once
// the current one has handed its result to that register.
module pure_pursuit_steering (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic               in_first_point,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_linear_cmd,
  output logic signed [31:0] out_angular_cmd,
  output logic signed [31:0] out_carrot_x,
  output logic signed [31:0] out_carrot_y,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  pps_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [30:0] lookahead_r, speed_r, gain_r;
  logic [61:0] look_sq_r;
  logic        cfg_wr;
  pps_pkg::cfg_idx_t cfg_idx;

  // Path length and latched query.
  logic [pps_pkg::LEN_W-1:0] path_len_r;
  logic signed [31:0] rx_r, ry_r;
  logic signed [32:0] c_r, s_r;
  logic [31:0]        n_r;
  logic signed [31:0] wsq, zsq, wz;

  // Scan pipeline.
  logic [pps_pkg::LEN_W-1:0] rd_cnt_r, s1_idx_r, s2_idx_r;
  logic               s1_v_r, s2_v_r;
  logic               issue, hit;
  logic [31:0]        mem_px, mem_py;
  logic signed [32:0] dx1, dy1;
  logic [31:0]        ax1, ay1;
  logic signed [31:0] s2_px_r, s2_py_r;
  logic signed [32:0] s2_dx_r, s2_dy_r;
  logic [63:0]        s2_xx_r, s2_yy_r;
  logic [64:0]        sum65;
  logic [63:0]        lsq;

  // Carrot and command datapath.
  logic signed [31:0] cx_r, cy_r;
  logic signed [32:0] dx_r, dy_r;
  logic [63:0]        lsq_r;
  logic signed [31:0] cq_r, sq_r;
  logic signed [64:0] pc_r, ps_r;
  logic signed [65:0] ydiff, yadj;
  logic signed [35:0] y_r;
  logic [35:0]        ymag;
  logic [63:0]        num_r;
  logic               neg_r;
  logic [32:0]        cmag, smag;
  logic [31:0]        qsat;
  logic [31:0]        limit;

  // Divider hookup.
  logic                         div_start;
  logic [pps_pkg::DIV_N_W-1:0]  div_dividend;
  logic [pps_pkg::DIV_D_W-1:0]  div_divisor;
  logic                         div_done;
  logic [pps_pkg::DIV_N_W-1:0]  div_q;

  // Result holding and output registers.
  pps_pkg::status_t   res_status_r;
  logic signed [31:0] res_ang_r, res_cx_r, res_cy_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_lin_r, out_ang_r, out_cx_r, out_cy_r;

  logic accept, store_acc, query_acc, mem_we, out_load;
  logic [pps_pkg::IDX_W-1:0] waddr;
  logic div_wait, store_full;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = pps_pkg::cfg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookahead_r <= pps_pkg::RST_LOOKAHEAD;
      speed_r     <= pps_pkg::RST_SPEED;
      gain_r      <= pps_pkg::RST_GAIN;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pps_pkg::CFG_LOOKAHEAD: lookahead_r <= cfg_pwdata[30:0];
        pps_pkg::CFG_SPEED:     speed_r     <= cfg_pwdata[30:0];
        pps_pkg::CFG_GAIN:      gain_r      <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pps_pkg::CFG_LOOKAHEAD: cfg_prdata = {1'b0, lookahead_r};
      pps_pkg::CFG_SPEED:     cfg_prdata = {1'b0, speed_r};
      pps_pkg::CFG_GAIN:      cfg_prdata = {1'b0, gain_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // Squared look-ahead, refreshed every cycle; the user must keep the block idle around writes (not enforced).
  always_ff @(posedge clk) begin
    look_sq_r <= 62'(lookahead_r) * 62'(lookahead_r);
  end

  // ---------------------------------------------------------------- accept
  assign in_ready  = (state_r == pps_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign store_acc = accept && (in_opcode == pps_pkg::OP_STORE);
  assign query_acc = accept && (in_opcode == pps_pkg::OP_QUERY);
  assign mem_we    = store_acc && (in_first_point || (path_len_r < pps_pkg::LEN_MAX));
  assign waddr     = in_first_point ? '0 : path_len_r[pps_pkg::IDX_W-1:0];

  always_comb begin
    wsq = in_quat_w * in_quat_w;
    zsq = in_quat_z * in_quat_z;
    wz  = in_quat_w * in_quat_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_len_r <= '0;
    end else if (mem_we) begin
      path_len_r <= in_first_point ? pps_pkg::LEN_W'(1) : path_len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      rx_r <= in_point_x;
      ry_r <= in_point_y;
      c_r  <= 33'(wsq) - 33'(zsq);
      s_r  <= {wz, 1'b0};
      n_r  <= 32'(wsq) + 32'(zsq);
    end
  end

  // ---------------------------------------------------------------- memory
  // Writes happen only in the idle state and reads only while scanning, so
  // the two ports never touch the same entry in the same cycle.
  pps_path_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wx    (in_point_x),
    .wy    (in_point_y),
    .re    (issue),
    .raddr (rd_cnt_r[pps_pkg::IDX_W-1:0]),
    .rx    (mem_px),
    .ry    (mem_py)
  );

  // ---------------------------------------------------------------- scan
  always_comb begin
    dx1   = {mem_px[31], mem_px} - {rx_r[31], rx_r};
    dy1   = {mem_py[31], mem_py} - {ry_r[31], ry_r};
    ax1   = dx1[32] ? 32'(-dx1) : 32'(dx1);
    ay1   = dy1[32] ? 32'(-dy1) : 32'(dy1);
    sum65 = {1'b0, s2_xx_r} + {1'b0, s2_yy_r};
    lsq   = sum65[64] ? '1 : sum65[63:0];
    // The last stored point is the carrot when nothing reaches the look-ahead.
    hit   = s2_v_r && ((lsq >= {2'b00, look_sq_r}) ||
                       (s2_idx_r == path_len_r - 1'b1));
    issue = (state_r == pps_pkg::S_SCAN) && (rd_cnt_r < path_len_r) && !hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      rd_cnt_r <= '0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r && (state_r == pps_pkg::S_SCAN) && !hit;
      if (query_acc) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx_r <= rd_cnt_r;
    end
    if (s1_v_r) begin
      s2_idx_r <= s1_idx_r;
      s2_px_r  <= mem_px;
      s2_py_r  <= mem_py;
      s2_dx_r  <= dx1;
      s2_dy_r  <= dy1;
      s2_xx_r  <= 64'(ax1) * 64'(ax1);
      s2_yy_r  <= 64'(ay1) * 64'(ay1);
    end
    if (hit && (state_r == pps_pkg::S_SCAN)) begin
      cx_r  <= s2_px_r;
      cy_r  <= s2_py_r;
      dx_r  <= s2_dx_r;
      dy_r  <= s2_dy_r;
      lsq_r <= lsq;
    end
  end

  // ---------------------------------------------------------------- divider
  always_comb begin
    cmag = c_r[32] ? 33'(-c_r) : 33'(c_r);
    smag = s_r[32] ? 33'(-s_r) : 33'(s_r);
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 64'(n_r);
    unique case (state_r)
      pps_pkg::S_CGO: begin
        div_start    = (n_r != '0);
        div_dividend = pps_pkg::DIV_N_W'(cmag) << 30;
      end
      pps_pkg::S_SGO: begin
        div_start    = 1'b1;
        div_dividend = pps_pkg::DIV_N_W'(smag) << 30;
      end
      pps_pkg::S_AGO: begin
        div_start    = 1'b1;
        div_dividend = {num_r, 17'd0};
        div_divisor  = lsq_r;
      end
      default: ;
    endcase
  end

  pps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------- command
  always_comb begin
    ydiff = 66'(pc_r) - 66'(ps_r);
    // Division by 2^30 rounds toward zero, so negative values get a bias.
    yadj  = ydiff + (ydiff[65] ? 66'sd1073741823 : 66'sd0);
    ymag  = y_r[35] ? 36'(-y_r) : 36'(y_r);
    limit = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    qsat  = (div_q > pps_pkg::DIV_N_W'(limit)) ? limit : div_q[31:0];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pps_pkg::S_IDLE: begin
        if (store_acc) begin
          res_status_r <= mem_we ? pps_pkg::ST_STORED : pps_pkg::ST_DROPPED;
        end else begin
          res_status_r <= pps_pkg::ST_EMPTY;
        end
        res_ang_r <= '0;
        res_cx_r  <= '0;
        res_cy_r  <= '0;
      end
      pps_pkg::S_CGO: begin
        if (n_r == '0) begin
          cq_r <= signed'(pps_pkg::ONE_Q30);
          sq_r <= '0;
        end
      end
      pps_pkg::S_CWAIT: begin
        if (div_done) begin
          cq_r <= c_r[32] ? 32'(-div_q[31:0]) : div_q[31:0];
        end
      end
      pps_pkg::S_SWAIT: begin
        if (div_done) begin
          sq_r <= s_r[32] ? 32'(-div_q[31:0]) : div_q[31:0];
        end
      end
      pps_pkg::S_MULT: begin
        pc_r <= 65'(cq_r) * 65'(dy_r);
        ps_r <= 65'(sq_r) * 65'(dx_r);
      end
      pps_pkg::S_YSUM: begin
        y_r <= 36'(yadj >>> 30);
      end
      pps_pkg::S_GAIN: begin
        num_r        <= 64'(ymag[32:0]) * 64'(gain_r);
        neg_r        <= y_r[35];
        res_status_r <= pps_pkg::ST_CMD;
        res_ang_r    <= '0;
        res_cx_r     <= cx_r;
        res_cy_r     <= cy_r;
      end
      pps_pkg::S_AWAIT: begin
        if (div_done) begin
          res_ang_r <= neg_r ? 32'(-qsat) : qsat;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pps_pkg::S_IDLE: begin
        if (store_acc) begin
          state_nxt = pps_pkg::S_RESP;
        end else if (query_acc) begin
          state_nxt = (path_len_r == '0) ? pps_pkg::S_RESP : pps_pkg::S_SCAN;
        end
      end
      pps_pkg::S_SCAN:  if (hit) state_nxt = pps_pkg::S_CGO;
      pps_pkg::S_CGO:   state_nxt = (n_r == '0) ? pps_pkg::S_MULT : pps_pkg::S_CWAIT;
      pps_pkg::S_CWAIT: if (div_done) state_nxt = pps_pkg::S_SGO;
      pps_pkg::S_SGO:   state_nxt = pps_pkg::S_SWAIT;
      pps_pkg::S_SWAIT: if (div_done) state_nxt = pps_pkg::S_MULT;
      pps_pkg::S_MULT:  state_nxt = pps_pkg::S_YSUM;
      pps_pkg::S_YSUM:  state_nxt = pps_pkg::S_GAIN;
      pps_pkg::S_GAIN: begin
        state_nxt = ((lsq_r > pps_pkg::MIN_DIST_SQ) && (y_r != '0)) ?
                    pps_pkg::S_AGO : pps_pkg::S_RESP;
      end
      pps_pkg::S_AGO:   state_nxt = pps_pkg::S_AWAIT;
      pps_pkg::S_AWAIT: if (div_done) state_nxt = pps_pkg::S_RESP;
      pps_pkg::S_RESP:  if (out_load) state_nxt = pps_pkg::S_IDLE;
      default:          state_nxt = pps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  assign out_load = (state_r == pps_pkg::S_RESP) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_lin_r    <= (res_status_r == pps_pkg::ST_CMD) ? {1'b0, speed_r} : '0;
      out_ang_r    <= res_ang_r;
      out_cx_r     <= res_cx_r;
      out_cy_r     <= res_cy_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_linear_cmd  = out_lin_r;
  assign out_angular_cmd = out_ang_r;
  assign out_carrot_x    = out_cx_r;
  assign out_carrot_y    = out_cy_r;

  // ---------------------------------------------------------------- checks
  assign div_wait   = (state_r == pps_pkg::S_CWAIT) || (state_r == pps_pkg::S_SWAIT) ||
                      (state_r == pps_pkg::S_AWAIT);
  assign store_full = store_acc && !in_first_point && (path_len_r == pps_pkg::LEN_MAX);

`include "pure_pursuit_steering_macros.svh"

  `PPS_ASSERT_ALWAYS(a_len_bound, path_len_r <= pps_pkg::LEN_MAX)
  `PPS_ASSERT_IMPLY(a_scan_idx, s2_v_r, s2_idx_r < path_len_r)
  `PPS_ASSERT_IMPLY(a_div_expected, div_done, div_wait)
  `PPS_ASSERT_NEXT(a_drop_full, store_full, res_status_r == pps_pkg::ST_DROPPED)

endmodule

// File: tb/sv/pure_pursuit_steering_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pure pursuit steering testbench
// Drives path points and pose queries through the steering block, predicts
// every result word in a behavioral model of its own and checks each field.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_test;

  typedef struct {
    logic              op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic              first;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } word_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] lin;
    logic [31:0] ang;
    logic [31:0] cx;
    logic [31:0] cy;
  } cmd_t;

  typedef struct {
    word_t w;
    bit    typed;
    cmd_t  res;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic in_opcode, in_first_point;
  logic signed [31:0] in_point_x, in_point_y;
  logic signed [15:0] in_quat_z, in_quat_w;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic signed [31:0] out_linear_cmd, out_angular_cmd, out_carrot_x, out_carrot_y;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  pure_pursuit_steering dut (.*);

  // Predictor state.
  logic [31:0] model_px [pps_pkg::MAX_POINTS];
  logic [31:0] model_py [pps_pkg::MAX_POINTS];
  int unsigned model_len;
  logic [30:0] model_look, model_speed, model_gain;

  cmd_t expected_cmds[$];
  int errors;
  bit stall_enable;
  bit long_hold;
  bit drain;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] sq_dist(longint dx, longint dy);
    logic [63:0] ax, ay, a, b, s;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    a = ax * ax;
    b = ay * ay;
    s = a + b;
    return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
  endfunction

  // floor(num * 2^17 / den) with the quotient clamped to limit.
  function automatic logic [63:0] steer_div(logic [63:0] num, logic [63:0] den,
                                            logic [63:0] limit);
    logic [127:0] q;
    q = {64'd0, num};
    q = (q << 17) / {64'd0, den};
    return (q > {64'd0, limit}) ? limit : q[63:0];
  endfunction

  function automatic cmd_t predict_cmd(word_t w);
    cmd_t r;
    longint rx, ry, px, py, dx, dy, qz, qw, c, s, n, cq, sq, yr;
    logic [63:0] look_sq, lsq, num, m;
    int unsigned k, sel;
    r = '{2'(pps_pkg::ST_CMD), 0, 0, 0, 0};
    if (w.op == pps_pkg::OP_STORE) begin
      if (w.first) model_len = 0;
      if (model_len < pps_pkg::MAX_POINTS) begin
        model_px[model_len] = w.x;
        model_py[model_len] = w.y;
        model_len++;
        r.status = pps_pkg::ST_STORED;
      end else begin
        r.status = pps_pkg::ST_DROPPED;
      end
      return r;
    end
    if (model_len == 0) begin
      r.status = pps_pkg::ST_EMPTY;
      return r;
    end
    rx = w.x;
    ry = w.y;
    qz = w.qz;
    qw = w.qw;
    look_sq = 64'(model_look) * 64'(model_look);
    sel = model_len - 1;
    for (k = 0; k < model_len; k++) begin
      if (sq_dist(longint'($signed(model_px[k])) - rx,
                  longint'($signed(model_py[k])) - ry) >= look_sq) begin
        sel = k;
        break;
      end
    end
    px = $signed(model_px[sel]);
    py = $signed(model_py[sel]);
    dx = px - rx;
    dy = py - ry;
    lsq = sq_dist(dx, dy);
    c = qw * qw - qz * qz;
    s = 2 * qw * qz;
    n = qw * qw + qz * qz;
    if (n == 0) begin
      cq = 64'sd1 << 30;
      sq = 0;
    end else begin
      cq = (c * (64'sd1 << 30)) / n;
      sq = (s * (64'sd1 << 30)) / n;
    end
    yr = (cq * dy - sq * dx) / (64'sd1 << 30);
    if (lsq > pps_pkg::MIN_DIST_SQ && yr != 0) begin
      num = (yr < 0 ? -yr : yr) * 64'(model_gain);
      if (yr > 0) begin
        r.ang = steer_div(num, lsq, 64'h7FFF_FFFF);
      end else begin
        m = steer_div(num, lsq, 64'h8000_0000);
        r.ang = 32'(-m);
      end
    end
    r.lin = 32'(model_speed);
    r.cx = 32'(px);
    r.cy = 32'(py);
    return r;
  endfunction

  task automatic write_reg(pps_pkg::cfg_idx_t idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(4 * int'(idx));
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      pps_pkg::CFG_LOOKAHEAD: model_look = value[30:0];
      pps_pkg::CFG_SPEED:     model_speed = value[30:0];
      default:                model_gain = value[30:0];
    endcase
  endtask

  // Idle between phases: nothing expected, then the block's own settle time.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // The valid stays up from one word to the next unless an idle gap is drawn.
  task automatic send_word(word_t w, bit typed, cmd_t typed_res);
    cmd_t p;
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= w.op;
    in_point_x <= w.x;
    in_point_y <= w.y;
    in_first_point <= w.first;
    in_quat_z <= w.qz;
    in_quat_w <= w.qw;
    do @(posedge clk); while (!in_ready);
    p = predict_cmd(w);
    if (typed) p = typed_res;
    expected_cmds.push_back(p);
  endtask

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
    endcase
  endfunction

  function automatic word_t rand_word(bit query_bias);
    word_t w;
    w.op = query_bias ? ($urandom_range(0, 2) == 0) : 1'($urandom_range(0, 1));
    w.x = rand_coord();
    w.y = rand_coord();
    w.first = ($urandom_range(0, 15) == 0);
    w.qz = rand_quat();
    w.qw = rand_quat();
    return w;
  endfunction

  // Result side: random stalls, one long hold-off, field checks.
  initial begin
    cmd_t e;
    int hold;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 3000; hold++) @(posedge clk);
        long_hold = 0;
      end else if (stall_enable && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_cmds.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            errors++;
          end
          if (out_linear_cmd !== e.lin) begin
            $error("linear_cmd: expected %0h, got %0h", e.lin, out_linear_cmd);
            errors++;
          end
          if (out_angular_cmd !== e.ang) begin
            $error("angular_cmd: expected %0h, got %0h", e.ang, out_angular_cmd);
            errors++;
          end
          if (out_carrot_x !== e.cx) begin
            $error("carrot_x: expected %0h, got %0h", e.cx, out_carrot_x);
            errors++;
          end
          if (out_carrot_y !== e.cy) begin
            $error("carrot_y: expected %0h, got %0h", e.cy, out_carrot_y);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    row_t directed[$];
    word_t w;
    cmd_t none;
    int i, phase, n, timeout;
    logic [31:0] looks[4], speeds[4], gains[4];
    looks = '{32'h7FFF_FFFF, 32'd0, 32'd65536, 32'hFFFF_FFFF};
    speeds = '{32'd0, 32'h7FFF_FFFF, 32'd131072, 32'd19661};
    gains = '{32'h7FFF_FFFF, 32'd0, 32'd32768, 32'd65536};
    none = '{2'(pps_pkg::ST_CMD), 0, 0, 0, 0};
    errors = 0;
    stall_enable = 1;
    long_hold = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = pps_pkg::OP_STORE;
    in_point_x = 0;
    in_point_y = 0;
    in_first_point = 0;
    in_quat_z = 0;
    in_quat_w = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    model_len = 0;
    model_look = pps_pkg::RST_LOOKAHEAD;
    model_speed = pps_pkg::RST_SPEED;
    model_gain = pps_pkg::RST_GAIN;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: empty plan, extremes, rotations, zero quaternion.
    directed.push_back('{'{pps_pkg::OP_QUERY, 0, 0, 1, 0, 16384}, 1,
                         '{2'(pps_pkg::ST_EMPTY), 0, 0, 0, 0}});
    directed.push_back('{'{pps_pkg::OP_STORE, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                           16'sh7FFF, 16'sh8000},
                         1, '{2'(pps_pkg::ST_STORED), 0, 0, 0, 0}});
    directed.push_back('{'{pps_pkg::OP_STORE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0}, 1,
                         '{2'(pps_pkg::ST_STORED), 0, 0, 0, 0}});
    directed.push_back('{'{pps_pkg::OP_QUERY, 32'h8000_0000, 32'h8000_0000, 0, 0, 16384},
                         0, none});
    directed.push_back('{'{pps_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 16384, 0},
                         0, none});
    directed.push_back('{'{pps_pkg::OP_QUERY, 0, 0, 0, 0, 0}, 0, none});
    directed.push_back('{'{pps_pkg::OP_QUERY, 0, 0, 0, -16384, -16384}, 0, none});
    directed.push_back('{'{pps_pkg::OP_STORE, 1, 1, 1, 0, 0}, 1,
                         '{2'(pps_pkg::ST_STORED), 0, 0, 0, 0}});
    directed.push_back('{'{pps_pkg::OP_QUERY, 0, 0, 0, 0, 16384}, 0, none});
    directed.push_back('{'{pps_pkg::OP_STORE, 65536, 0, 0, 0, 0}, 0, none});
    directed.push_back('{'{pps_pkg::OP_STORE, 0, 65536, 0, 0, 0}, 0, none});
    directed.push_back('{'{pps_pkg::OP_QUERY, 0, 0, 0, 0, 16384}, 0, none});
    directed.push_back('{'{pps_pkg::OP_QUERY, 0, 0, 0, 11585, 11585}, 0, none});
    directed.push_back('{'{pps_pkg::OP_QUERY, 0, 0, 0, -11585, 11585}, 0, none});
    directed.push_back('{'{pps_pkg::OP_QUERY, 32'h0000_8000, 0, 0, 16384, 16384}, 0, none});
    foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].res);

    // Fill the path to capacity and beyond.
    for (i = 0; i < pps_pkg::MAX_POINTS + 3; i++) begin
      w = '{pps_pkg::OP_STORE, rand_coord(), rand_coord(), i == 0, rand_quat(), rand_quat()};
      send_word(w, 0, none);
    end
    w = '{pps_pkg::OP_QUERY, 0, 0, 1, rand_quat(), rand_quat()};
    send_word(w, 0, none);
    wait_idle();

    // Random phases under a range of register settings.
    for (phase = 0; phase < 5; phase++) begin
      if (phase < 4) begin
        write_reg(pps_pkg::CFG_LOOKAHEAD,
                  phase == 2 ? $urandom_range(0, 8 << 16) : looks[phase]);
        write_reg(pps_pkg::CFG_SPEED, speeds[phase]);
        write_reg(pps_pkg::CFG_GAIN, gains[phase]);
      end
      if (phase == 1) long_hold = 1;
      if (phase == 4) stall_enable = 0;
      // Short paths keep query scans brief.
      n = 0;
      while (n < 90) begin
        w = '{pps_pkg::OP_STORE, rand_coord(), rand_coord(), 1, rand_quat(), rand_quat()};
        send_word(w, 0, none);
        n++;
        repeat ($urandom_range(0, 6)) begin
          w = rand_word(0);
          w.op = pps_pkg::OP_STORE;
          w.first = 0;
          send_word(w, 0, none);
          n++;
        end
        repeat ($urandom_range(1, 4)) begin
          w = rand_word(0);
          w.op = pps_pkg::OP_QUERY;
          send_word(w, 0, none);
          n++;
        end
        if ($urandom_range(0, 9) == 0) begin
          w = rand_word(1);
          send_word(w, 0, none);
          n++;
        end
      end
      wait_idle();
    end

    timeout = 0;
    while (expected_cmds.size() != 0 && timeout < 100000) begin
      @(posedge clk);
      timeout++;
    end
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
